// ----- rtl/npcs_pkg.sv -----
// shared constants, types and state encoding for the nearest palette color search
// no dependencies; imported by every module of the block

package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

  localparam int SLOT_W = 8;
  localparam int CHAN_W = 8;
  localparam int COUNT_W = 9;
  localparam int DIST_W = 18;
  localparam int SQ_W = 2 * CHAN_W;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUBLISH
  } npcs_state_t;

  typedef struct packed {
    logic load_query;
    logic write_entry;
    logic issue;
    logic publish;
  } npcs_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pipe_empty;
    logic out_free;
  } npcs_status_t;

endpackage

// ----- rtl/npcs_ctrl.sv -----
// controller state machine: input handshake, scan sequencing, result hand-off
// depends on npcs_pkg

module npcs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_ready,
  input  npcs_pkg::npcs_status_t status,
  output npcs_pkg::npcs_cmd_t    cmd
);
  import npcs_pkg::*;

  npcs_state_t state;
  npcs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_QUERY) begin
            cmd.load_query = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.write_entry = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_done && status.pipe_empty) begin
          state_next = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/npcs_dpath.sv -----
// datapath: palette memory, distance pipeline, running minimum, result register
// depends on npcs_pkg

module npcs_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  npcs_pkg::npcs_cmd_t                cmd,
  output npcs_pkg::npcs_status_t             status,
  input  logic [npcs_pkg::SLOT_W-1:0]        entry_slot,
  input  logic [npcs_pkg::CHAN_W-1:0]        red,
  input  logic [npcs_pkg::CHAN_W-1:0]        green,
  input  logic [npcs_pkg::CHAN_W-1:0]        blue,
  input  logic [npcs_pkg::COUNT_W-1:0]       search_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [npcs_pkg::SLOT_W-1:0]        best_slot,
  output logic [npcs_pkg::DIST_W-1:0]        best_distance,
  output logic                              exact_hit
);
  import npcs_pkg::*;

  function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic [3*CHAN_W-1:0] mem [PALETTE_DEPTH];

  logic [CHAN_W-1:0] q_red, q_green, q_blue;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  addr_cnt;
  logic [CMP_W-1:0]  count_ext;
  logic              issue_done;
  logic              issue_fire;
  logic              slot_ok;

  // pipeline: memory read, squares, distance sum, compare
  logic              v1, v2, v3;
  logic [ADDR_W-1:0] idx1, idx2, idx3;
  logic [3*CHAN_W-1:0] rd_data;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic [DIST_W-1:0] dist3;

  logic              found;
  logic              exact;
  logic [ADDR_W-1:0] best_idx;
  logic [DIST_W-1:0] best_dist;

  assign count_ext  = CMP_W'(search_count);
  assign slot_ok    = CMP_W'(entry_slot) < CMP_W'(PALETTE_DEPTH);
  assign issue_done = (addr_cnt == count_q);
  assign issue_fire = cmd.issue && !issue_done && !exact;

  assign status.scan_done  = issue_done || exact;
  assign status.pipe_empty = !v1 && !v2 && !v3;
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.write_entry && slot_ok) begin
      mem[ADDR_W'(entry_slot)] <= {red, green, blue};
    end
    rd_data <= mem[addr_cnt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
      if (count_ext > CMP_W'(PALETTE_DEPTH)) begin
        count_q <= CNT_W'(PALETTE_DEPTH);
      end else begin
        count_q <= CNT_W'(count_ext);
      end
    end
    idx1 <= addr_cnt[ADDR_W-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    sq_r <= chan_sq(rd_data[3*CHAN_W-1:2*CHAN_W], q_red);
    sq_g <= chan_sq(rd_data[2*CHAN_W-1:CHAN_W], q_green);
    sq_b <= chan_sq(rd_data[CHAN_W-1:0], q_blue);
    dist3 <= DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_cnt  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      found     <= 1'b0;
      exact     <= 1'b0;
      best_idx  <= '0;
      best_dist <= '0;
    end else begin
      v1 <= issue_fire;
      v2 <= v1;
      v3 <= v2;
      if (cmd.load_query) begin
        addr_cnt  <= '0;
        found     <= 1'b0;
        exact     <= 1'b0;
        best_idx  <= '0;
        best_dist <= '0;
      end else begin
        if (issue_fire) begin
          addr_cnt <= addr_cnt + 1'b1;
        end
        // entries still in flight after an exact hit are dropped
        if (v3 && !exact) begin
          if (dist3 == '0) begin
            exact     <= 1'b1;
            best_idx  <= idx3;
            best_dist <= '0;
          end else if (!found || dist3 < best_dist) begin
            found     <= 1'b1;
            best_idx  <= idx3;
            best_dist <= dist3;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      best_slot     <= SLOT_W'(best_idx);
      best_distance <= best_dist;
      exact_hit     <= exact;
    end
  end

endmodule

// ----- rtl/nearest_palette_color_search.sv -----
// nearest palette color search: palette write, squared rgb distance scan, best index
// one query at a time: the input closes for the whole scan and reopens in the cycle after
// the result is registered (single palette read port, 3-stage distance pipe); a scan stops
// early on an exact hit; palette writes are taken in the idle state
// rst (synchronous) clears control state; the palette is not cleared, write before search

module nearest_palette_color_search (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] entry_slot, [15:8] red, [23:16] green, [31:24] blue, [40:32] search_count,
  // [47:41] zero
  input  logic [npcs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] cmd (0 write entry, 1 query)
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] best_slot, [25:8] best_distance, [31:26] zero
  output logic [npcs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] exact_hit
  output logic                              m_axis_tuser
);
  import npcs_pkg::*;

  npcs_cmd_t    cmd;
  npcs_status_t status;

  logic [SLOT_W-1:0] best_slot;
  logic [DIST_W-1:0] best_distance;
  logic              exact_hit;

  // state machine only sequences; all storage and arithmetic live in the datapath
  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // field unpacking from the input transfer, lowest field first
  npcs_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .entry_slot    (s_axis_tdata[7:0]),
    .red           (s_axis_tdata[15:8]),
    .green         (s_axis_tdata[23:16]),
    .blue          (s_axis_tdata[31:24]),
    .search_count  (s_axis_tdata[40:32]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .best_slot     (best_slot),
    .best_distance (best_distance),
    .exact_hit     (exact_hit)
  );

  // result register output, padded to whole bytes
  assign m_axis_tdata = {(M_TDATA_W - SLOT_W - DIST_W)'(0), best_distance, best_slot};
  assign m_axis_tuser = exact_hit;

endmodule

// ----- rtl/npcs_checker.sv -----
// port-level checks for the nearest palette color search
// depends on npcs_pkg; bound to nearest_palette_color_search

module npcs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [npcs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import npcs_pkg::*;

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an exact hit always carries distance zero
  a_exact_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:8] == '0)
    else $error("exact hit with nonzero distance");

  // distance cannot exceed three full-scale channel squares
  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[25:8] <= 18'd195075)
    else $error("distance out of range");

  // a query transfer starts a scan, so the input closes on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
    else $error("input open during scan");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

// self-checking bench for nearest_palette_color_search: palette writes and nearest-color
// queries go in on the input stream, each query result is checked against a local model
// depends on npcs_pkg and the nearest_palette_color_search rtl

module testbench;
  import npcs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int IDLE_PCT = 30;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  // {red, green, blue}, red in the top byte
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [SLOT_W-1:0] best_slot;
    logic [DIST_W-1:0] best_distance;
    logic              exact_hit;
  } match_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  // local copy of the palette and which slots hold a written color
  rgb_t   palette_copy [PALETTE_DEPTH];
  bit     palette_written [PALETTE_DEPTH];
  int     filled;  // slots 0..filled-1 are all written, queries never search past them
  match_t expected_matches [$];
  bit     steady;  // no idling on either side while set

  int     mismatch_count;
  int     writes_sent;
  int     queries_sent;
  int     saturated_sent;
  int     results_seen;
  int     exact_seen;
  int     cycle_count;
  match_t seen_match;
  match_t want_match;

  nearest_palette_color_search i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // squared rgb distance scan over the leading entries, earliest slot wins ties,
  // a zero distance stops the scan, an empty search gives all zeros
  function automatic match_t nearest_match(rgb_t color, int count);
    match_t best;
    int     span;
    int     sq_dist;
    int     dr;
    int     dg;
    int     db;
    bit     found;
    best = '0;
    found = 1'b0;
    span = (count > PALETTE_DEPTH) ? PALETTE_DEPTH : count;
    for (int i = 0; i < span; i++) begin
      dr = int'(palette_copy[i].red) - int'(color.red);
      dg = int'(palette_copy[i].green) - int'(color.green);
      db = int'(palette_copy[i].blue) - int'(color.blue);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist == 0) begin
        best.best_slot = SLOT_W'(i);
        best.best_distance = '0;
        best.exact_hit = 1'b1;
        return best;
      end
      if (!found || sq_dist < int'(best.best_distance)) begin
        found = 1'b1;
        best.best_slot = SLOT_W'(i);
        best.best_distance = DIST_W'(sq_dist);
      end
    end
    return best;
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] chan);
    int v;
    v = int'(chan) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  // query colors: exact copies of stored entries, near misses, or anything
  function automatic rgb_t pick_query_color();
    rgb_t color;
    int   mode;
    mode = $urandom_range(99);
    if (filled == 0 || mode >= 70) return rgb_t'(24'($urandom));
    color = palette_copy[$urandom_range(filled - 1)];
    if (mode >= 35) begin
      color.red = nudge(color.red);
      color.green = nudge(color.green);
      color.blue = nudge(color.blue);
    end
    return color;
  endfunction

  // mostly short searches, some of any length within the written prefix, a few empty or oversized
  function automatic int pick_count();
    int r;
    int short_top;
    r = $urandom_range(99);
    short_top = (filled < 24) ? filled : 24;
    if (filled == 0 || r < 5) return 0;
    if (r < 75) return $urandom_range(1, short_top);
    if (r < 92 || filled < PALETTE_DEPTH) return $urandom_range(1, filled);
    return $urandom_range(PALETTE_DEPTH, COUNT_MAX);
  endfunction

  // one input transfer, with random idle cycles ahead of it; the model is updated on accept
  task automatic send_item(logic cmd, logic [SLOT_W-1:0] slot, rgb_t color, int count);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {{(S_TDATA_W - 41){1'b0}}, COUNT_W'(count), color.blue, color.green,
                     color.red, slot};
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == CMD_WRITE) begin
      palette_copy[slot] = color;
      palette_written[slot] = 1'b1;
      while (filled < PALETTE_DEPTH && palette_written[filled]) filled++;
      writes_sent++;
    end else begin
      expected_matches.push_back(nearest_match(color, count));
      queries_sent++;
      if (count > PALETTE_DEPTH) saturated_sent++;
    end
  endtask

  task automatic write_entry(logic [SLOT_W-1:0] slot, rgb_t color);
    send_item(CMD_WRITE, slot, color, int'($urandom_range(COUNT_MAX)));
  endtask

  // the slot field means nothing to a query, so it carries noise
  task automatic run_query(rgb_t color, int count);
    send_item(CMD_QUERY, SLOT_W'($urandom), color, count);
  endtask

  // sender holds off until every outstanding query has answered
  task automatic pause_until_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  // empty searches, issued before anything is written
  task automatic test_empty_search();
    run_query(rgb_t'(24'h000000), 0);
    run_query(rgb_t'(24'hFFFFFF), 0);
  endtask

  // small known palette: extremes of distance, exact hits, ties and the last entry
  task automatic test_directed_cases();
    rgb_t seed_colors [8];
    seed_colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                    24'h0000FF, 24'hFF0000, 24'h808080, 24'h0A141E};
    for (int i = 0; i < 8; i++) write_entry(SLOT_W'(i), seed_colors[i]);
    run_query(rgb_t'(24'hFFFFFF), 1);  // white against black: largest distance
    run_query(rgb_t'(24'h000000), 8);  // exact hit on the first entry
    run_query(rgb_t'(24'h000000), 1);
    run_query(rgb_t'(24'hFF0000), 8);  // exact hit on the earlier of two equal entries
    run_query(rgb_t'(24'hFE0000), 8);  // tie at distance one, earlier slot wins
    run_query(rgb_t'(24'h0000FF), 5);  // exact hit on the last searched entry
    run_query(rgb_t'(24'h808081), 7);
    run_query(rgb_t'(24'h0B141E), 8);  // nearest is the last entry of the search
    pause_until_drained();
  endtask

  // fill the rest of the palette in order, queries on the written prefix in between
  task automatic test_palette_fill();
    for (int slot = 8; slot < PALETTE_DEPTH; slot++) begin
      write_entry(SLOT_W'(slot), rgb_t'(24'($urandom)));
      if ($urandom_range(99) < 5)
        write_entry(SLOT_W'($urandom_range(filled - 1)), rgb_t'(24'($urandom)));
      if ($urandom_range(99) < 35) run_query(pick_query_color(), pick_count());
      if (slot == PALETTE_DEPTH / 2) pause_until_drained();
    end
  endtask

  // counts at and past the palette depth, which the block must clip, mixed with in-range counts
  task automatic test_saturated_count();
    int count;
    for (int n = 0; n < 60; n++) begin
      case (n % 4)
        0: count = PALETTE_DEPTH;
        1: count = COUNT_MAX;
        2: count = $urandom_range(PALETTE_DEPTH + 1, COUNT_MAX - 1);
        default: count = $urandom_range(1, PALETTE_DEPTH);
      endcase
      run_query(pick_query_color(), count);
    end
    pause_until_drained();
  endtask

  // overwrites and queries with neither side ever idling
  task automatic test_back_to_back();
    steady = 1'b1;
    for (int n = 0; n < 110; n++) begin
      if ($urandom_range(99) < 30)
        write_entry(SLOT_W'($urandom), rgb_t'(24'($urandom)));
      else
        run_query(pick_query_color(), pick_count());
    end
    steady = 1'b0;
  endtask

  // result side: random back-pressure, ready changes on the falling edge
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // every result transfer is matched against the oldest outstanding query
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_match.best_slot = m_axis_tdata[7:0];
      seen_match.best_distance = m_axis_tdata[25:8];
      seen_match.exact_hit = m_axis_tuser;
      results_seen++;
      if (seen_match.exact_hit) exact_seen++;
      if (expected_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: slot %0d distance %0d exact %0d",
                   seen_match.best_slot, seen_match.best_distance, seen_match.exact_hit);
      end else begin
        want_match = expected_matches.pop_front();
        if (seen_match.best_slot !== want_match.best_slot ||
            seen_match.best_distance !== want_match.best_distance ||
            seen_match.exact_hit !== want_match.exact_hit) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d mismatch: expected slot %0d distance %0d exact %0d, got slot %0d distance %0d exact %0d",
                     results_seen, want_match.best_slot, want_match.best_distance,
                     want_match.exact_hit, seen_match.best_slot,
                     seen_match.best_distance, seen_match.exact_hit);
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_WRITE;
    m_axis_tready = 1'b0;
    steady = 1'b0;
    filled = 0;
    foreach (palette_written[i]) palette_written[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_search();
    test_directed_cases();
    test_palette_fill();
    test_saturated_count();
    test_back_to_back();

    // let the last queries finish, then watch a little longer for stray results
    pause_until_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d palette writes and %0d queries (%0d with clipped counts)",
             writes_sent, queries_sent, saturated_sent);
    $display("checked %0d results, %0d exact hits, %0d mismatches",
             results_seen, exact_seen, mismatch_count);
    if (mismatch_count == 0 && expected_matches.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
